// File: src/gaussian_blur_window_filter_core_macros.svh
// Assertion macros for the Gaussian window filter core.
// Used by the top level only; compiles to nothing under SYNTHESIS.
`ifndef GAUSSIAN_BLUR_WINDOW_FILTER_CORE_MACROS_SVH
`define GAUSSIAN_BLUR_WINDOW_FILTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication checked at every rising clock edge outside reset.
`define GBWF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked at every rising clock edge outside reset.
`define GBWF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GBWF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define GBWF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: src/gbwf_pkg.sv
// Package of the Gaussian window filter: sizes, register codes, payload types
// and the weight lookup. Depends on nothing.
`timescale 1ns / 1ps

package gbwf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 2;
    localparam int MAX_HEIGHT = 4096;

    localparam int WIN       = 2 * MAX_RADIUS + 1;
    localparam int LINES     = 2 * MAX_RADIUS;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int SLOT_W    = $clog2(LINES);
    localparam int WIN_IDX_W = $clog2(WIN);

    localparam int WIDTH_W    = 11;
    localparam int RAD_W      = 2;
    localparam int WGT_W      = 16;
    localparam int CHAN_W     = 8;
    localparam int NCHAN      = 3;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int PROD_W = WGT_W + CHAN_W;
    localparam int CSUM_W = PROD_W + $clog2(WIN);
    localparam int TSUM_W = CSUM_W + $clog2(WIN);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH     = 3'd0,
        REG_KERNEL_RADIUS   = 3'd1,
        REG_WEIGHT_CENTER   = 3'd2,
        REG_WEIGHT_EDGE_ONE = 3'd3,
        REG_WEIGHT_DIAG_ONE = 3'd4,
        REG_WEIGHT_EDGE_TWO = 3'd5,
        REG_WEIGHT_KNIGHT   = 3'd6,
        REG_WEIGHT_DIAG_TWO = 3'd7
    } cfg_reg_t;

    localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH     = 11'd640;
    localparam logic [RAD_W-1:0]   RST_KERNEL_RADIUS   = 2'd1;
    localparam logic [WGT_W-1:0]   RST_WEIGHT_CENTER   = 16'd13380;
    localparam logic [WGT_W-1:0]   RST_WEIGHT_EDGE_ONE = 16'd8116;
    localparam logic [WGT_W-1:0]   RST_WEIGHT_DIAG_ONE = 16'd4922;
    localparam logic [WGT_W-1:0]   RST_WEIGHT_EDGE_TWO = 16'd0;
    localparam logic [WGT_W-1:0]   RST_WEIGHT_KNIGHT   = 16'd0;
    localparam logic [WGT_W-1:0]   RST_WEIGHT_DIAG_TWO = 16'd0;

    // Blue sits in the low byte.
    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } pixel_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } pos_t;

    typedef struct packed {
        pixel_t pix;
        pos_t   pos;
    } res_t;

    typedef struct packed {
        logic [WGT_W-1:0] center;
        logic [WGT_W-1:0] edge_one;
        logic [WGT_W-1:0] diag_one;
        logic [WGT_W-1:0] edge_two;
        logic [WGT_W-1:0] knight;
        logic [WGT_W-1:0] diag_two;
    } weights_t;

    typedef struct packed {
        logic adv;
        logic shift;
    } cell_ctrl_t;

    typedef pixel_t [WIN-1:0]               win_col_t;
    typedef pixel_t [LINES-1:0]             line_rd_t;
    typedef logic [WIN-1:0][WGT_W-1:0]      wgt_col_t;
    typedef logic [NCHAN-1:0][CSUM_W-1:0]   csum_t;

    // Weight of window position (row, col) for the given radius. Positions
    // outside the active kernel get zero.
    function automatic logic [WGT_W-1:0] weight_at(
        input logic [WIN_IDX_W-1:0] row,
        input logic [WIN_IDX_W-1:0] col,
        input logic [RAD_W-1:0]     rad,
        input weights_t             w
    );
        logic [WIN_IDX_W-1:0] ctr;
        logic [WIN_IDX_W-1:0] di;
        logic [WIN_IDX_W-1:0] dj;
        logic [WIN_IDX_W-1:0] dmin;
        logic [WIN_IDX_W-1:0] dmax;
        logic [WGT_W-1:0]     res;
        ctr  = WIN_IDX_W'(WIN - 1) - WIN_IDX_W'(rad);
        di   = (row > ctr) ? row - ctr : ctr - row;
        dj   = (col > ctr) ? col - ctr : ctr - col;
        dmin = (di <= dj) ? di : dj;
        dmax = (di <= dj) ? dj : di;
        if (dmax > WIN_IDX_W'(rad)) begin
            res = '0;
        end else if (dmax == WIN_IDX_W'(0)) begin
            res = w.center;
        end else if (dmax == WIN_IDX_W'(1)) begin
            res = (dmin == WIN_IDX_W'(0)) ? w.edge_one : w.diag_one;
        end else if (dmin == WIN_IDX_W'(0)) begin
            res = w.edge_two;
        end else if (dmin == WIN_IDX_W'(1)) begin
            res = w.knight;
        end else begin
            res = w.diag_two;
        end
        return res;
    endfunction

endpackage

// File: src/gbwf_line_buf.sv
// Line storage of the Gaussian window filter: one single-port memory per
// buffered row, read-before-write, with outputs ordered by row age. Uses gbwf_pkg.
`timescale 1ns / 1ps

module gbwf_line_buf
    import gbwf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [COL_W-1:0]  addr,
    input  logic [SLOT_W-1:0] slot,
    input  pixel_t            wr_data,
    output line_rd_t          rd_data
);

    pixel_t            q_all [LINES];
    logic [SLOT_W-1:0] slot_reg;

    for (genvar l = 0; l < LINES; l++) begin : g_line
        pixel_t mem [MAX_WIDTH];
        pixel_t q_reg;

        // The read returns the old contents when the same entry is written.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg <= mem[addr];
                if (slot == SLOT_W'(l))
                begin
                    mem[addr] <= wr_data;
                end
            end
        end

        assign q_all[l] = q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else if (en)
        begin
            slot_reg <= slot;
        end
    end

    // Entry k-1 is the row k lines above the row that was just written.
    for (genvar k = 1; k <= LINES; k++) begin : g_age
        assign rd_data[k-1] = q_all[slot_reg - SLOT_W'(k)];
    end

endmodule

// File: src/gbwf_cell.sv
// One window column cell of the Gaussian window filter: holds a column of
// pixels, passes it on, and forms the weighted column sum. Uses gbwf_pkg.
`timescale 1ns / 1ps

module gbwf_cell
    import gbwf_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  win_col_t   col_in,
    input  wgt_col_t   wgt,
    output win_col_t   col_out,
    output csum_t      csum
);

    win_col_t                               col_reg;
    logic [NCHAN-1:0][WIN-1:0][PROD_W-1:0]  prod_reg;
    logic [NCHAN-1:0][WIN-1:0][PROD_W-1:0]  prod_next;
    csum_t                                  csum_reg;
    csum_t                                  csum_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            col_reg <= col_in;
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < NCHAN; ch++)
        begin
            for (int k = 0; k < WIN; k++)
            begin
                prod_next[ch][k] = PROD_W'(wgt[k]) * PROD_W'(col_reg[k][CHAN_W*ch +: CHAN_W]);
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < NCHAN; ch++)
        begin
            csum_next[ch] = '0;
            for (int k = 0; k < WIN; k++)
            begin
                csum_next[ch] = csum_next[ch] + CSUM_W'(prod_reg[ch][k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            prod_reg <= prod_next;
            csum_reg <= csum_next;
        end
    end

    assign col_out = col_reg;
    assign csum    = csum_reg;

endmodule

// File: src/gaussian_blur_window_filter_core.sv
// Gaussian window filter core: raster pixels in, one filtered pixel per interior center.
// Throughput: one pixel per cycle while in_stall is low; each line memory gives one read and one write a cycle.
// Reset (rst_n, async): counters, valids, config to defaults; line memories not cleared.
// Uses gbwf_pkg, gbwf_line_buf, gbwf_cell and the assertion macro header.
`timescale 1ns / 1ps
`include "gaussian_blur_window_filter_core_macros.svh"

module gaussian_blur_window_filter_core
    import gbwf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CHAN_W-1:0]     pixel_b,
    input  logic [CHAN_W-1:0]     pixel_g,
    input  logic [CHAN_W-1:0]     pixel_r,
    input  logic                  frame_start,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CHAN_W-1:0]     out_b,
    output logic [CHAN_W-1:0]     out_g,
    output logic [CHAN_W-1:0]     out_r,
    output logic [ROW_W-1:0]      out_row,
    output logic [COL_W-1:0]      out_col,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers. The port is always ready; software must write
    // only while the block is idle, which the block does not enforce; so no shadowing is needed.
    // ------------------------------------------------------------------
    logic [WIDTH_W-1:0] image_width_reg;
    logic [RAD_W-1:0]   kernel_radius_reg;
    logic [WGT_W-1:0]   weight_center_reg;
    logic [WGT_W-1:0]   weight_edge_one_reg;
    logic [WGT_W-1:0]   weight_diag_one_reg;
    logic [WGT_W-1:0]   weight_edge_two_reg;
    logic [WGT_W-1:0]   weight_knight_reg;
    logic [WGT_W-1:0]   weight_diag_two_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg     <= RST_IMAGE_WIDTH;
            kernel_radius_reg   <= RST_KERNEL_RADIUS;
            weight_center_reg   <= RST_WEIGHT_CENTER;
            weight_edge_one_reg <= RST_WEIGHT_EDGE_ONE;
            weight_diag_one_reg <= RST_WEIGHT_DIAG_ONE;
            weight_edge_two_reg <= RST_WEIGHT_EDGE_TWO;
            weight_knight_reg   <= RST_WEIGHT_KNIGHT;
            weight_diag_two_reg <= RST_WEIGHT_DIAG_TWO;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:     image_width_reg     <= cfg_data[WIDTH_W-1:0];
                REG_KERNEL_RADIUS:   kernel_radius_reg   <= cfg_data[RAD_W-1:0];
                REG_WEIGHT_CENTER:   weight_center_reg   <= cfg_data[WGT_W-1:0];
                REG_WEIGHT_EDGE_ONE: weight_edge_one_reg <= cfg_data[WGT_W-1:0];
                REG_WEIGHT_DIAG_ONE: weight_diag_one_reg <= cfg_data[WGT_W-1:0];
                REG_WEIGHT_EDGE_TWO: weight_edge_two_reg <= cfg_data[WGT_W-1:0];
                REG_WEIGHT_KNIGHT:   weight_knight_reg   <= cfg_data[WGT_W-1:0];
                REG_WEIGHT_DIAG_TWO: weight_diag_two_reg <= cfg_data[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    // Out-of-range settings are clamped: a zero width or radius acts as
    // one, and anything above the supported maximum saturates to it.
    logic [WIDTH_W-1:0] width_eff;
    logic [RAD_W-1:0]   rad_eff;
    weights_t           wset;

    always_comb
    begin
        if (image_width_reg == '0)
        begin
            width_eff = WIDTH_W'(1);
        end
        else if (image_width_reg > WIDTH_W'(MAX_WIDTH))
        begin
            width_eff = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = image_width_reg;
        end

        if (kernel_radius_reg == '0)
        begin
            rad_eff = RAD_W'(1);
        end
        else if (kernel_radius_reg > RAD_W'(MAX_RADIUS))
        begin
            rad_eff = RAD_W'(MAX_RADIUS);
        end
        else
        begin
            rad_eff = kernel_radius_reg;
        end

        wset.center   = weight_center_reg;
        wset.edge_one = weight_edge_one_reg;
        wset.diag_one = weight_diag_one_reg;
        wset.edge_two = weight_edge_two_reg;
        wset.knight   = weight_knight_reg;
        wset.diag_two = weight_diag_two_reg;
    end

    // ------------------------------------------------------------------
    // Flow control. Every stage moves together on adv. The output stage
    // has a skid register, so a stalled consumer reaches the producer only
    // once the skid register fills; in_stall is simply the skid occupancy.
    // ------------------------------------------------------------------
    logic skid_valid_reg;
    logic out_valid_reg;
    logic adv;
    logic in_accept;

    assign adv       = !skid_valid_reg;
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Raster position. A frame start forces row 0, column 0. If the width
    // was lowered under the running column, that pixel opens a new row.
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_base;
    logic [ROW_W-1:0] row_base;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;
    logic [RAD_W:0]   span;
    logic             emit_cur;
    pos_t             ctr_pos;

    always_comb
    begin
        col_base = frame_start ? '0 : col_reg;
        row_base = frame_start ? '0 : row_reg;

        if (WIDTH_W'(col_base) >= width_eff)
        begin
            col_cur = '0;
            row_cur = row_base + ROW_W'(1);
        end
        else
        begin
            col_cur = col_base;
            row_cur = row_base;
        end

        if (WIDTH_W'(col_cur) + WIDTH_W'(1) >= width_eff)
        begin
            col_next = '0;
            row_next = row_cur + ROW_W'(1);
        end
        else
        begin
            col_next = col_cur + COL_W'(1);
            row_next = row_cur;
        end

        // The window around (row - R, col - R) is complete once the
        // current pixel sits at least 2R rows and 2R columns in.
        span        = {rad_eff, 1'b0};
        emit_cur    = (row_cur >= ROW_W'(span)) && (col_cur >= COL_W'(span));
        ctr_pos.row = row_cur - ROW_W'(rad_eff);
        ctr_pos.col = col_cur - COL_W'(rad_eff);
    end

    // ------------------------------------------------------------------
    // Line memories: read the stored rows above at this column and write
    // the new pixel into the slot of the current row.
    // ------------------------------------------------------------------
    pixel_t   pix_in;
    line_rd_t line_rd;

    assign pix_in.b = pixel_b;
    assign pix_in.g = pixel_g;
    assign pix_in.r = pixel_r;

    gbwf_line_buf u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (in_accept),
        .addr    (col_cur),
        .slot    (row_cur[SLOT_W-1:0]),
        .wr_data (pix_in),
        .rd_data (line_rd)
    );

    // ------------------------------------------------------------------
    // Pipeline stages, in order:
    //   line reads return, then the new column enters the cell chain;
    //   cells multiply, then cells sum their column;
    //   column sums are added across the chain.
    // ------------------------------------------------------------------
    logic   v1_reg;
    logic   v2_reg;
    logic   v3_reg;
    logic   v4_reg;
    logic   v5_reg;
    logic   emit1_reg;
    pixel_t pix1_reg;
    pos_t   pos1_reg;
    pos_t   pos2_reg;
    pos_t   pos3_reg;
    pos_t   pos4_reg;
    pos_t   pos5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (adv)
            begin
                v1_reg <= in_accept;
                v2_reg <= v1_reg && emit1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            emit1_reg <= emit_cur;
            pix1_reg  <= pix_in;
            pos1_reg  <= ctr_pos;
            pos2_reg  <= pos1_reg;
            pos3_reg  <= pos2_reg;
            pos4_reg  <= pos3_reg;
            pos5_reg  <= pos4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain. The newest column enters the last cell and every column
    // moves one cell toward index zero for each pixel. Each cell sees its
    // column of the weight matrix, which depends on configuration only.
    // ------------------------------------------------------------------
    win_col_t   new_col;
    win_col_t   col_link [WIN];
    csum_t      csum_all [WIN];
    cell_ctrl_t cell_ctrl;

    assign new_col[WIN-1]   = pix1_reg;
    assign cell_ctrl.adv    = adv;
    assign cell_ctrl.shift  = adv && v1_reg;

    for (genvar k = 1; k <= LINES; k++) begin : g_newcol
        assign new_col[WIN-1-k] = line_rd[k-1];
    end

    for (genvar j = 0; j < WIN; j++) begin : g_cell
        wgt_col_t wgt_col;
        win_col_t cell_in;

        for (genvar i = 0; i < WIN; i++) begin : g_wgt
            assign wgt_col[i] = weight_at(WIN_IDX_W'(i), WIN_IDX_W'(j), rad_eff, wset);
        end

        if (j == WIN - 1) begin : g_head
            assign cell_in = new_col;
        end else begin : g_body
            assign cell_in = col_link[j+1];
        end

        gbwf_cell u_cell (
            .clk     (clk),
            .ctrl    (cell_ctrl),
            .col_in  (cell_in),
            .wgt     (wgt_col),
            .col_out (col_link[j]),
            .csum    (csum_all[j])
        );
    end

    // Final accumulation over the chain, then truncation and saturation.
    logic [NCHAN-1:0][TSUM_W-1:0] tsum_reg;
    logic [NCHAN-1:0][TSUM_W-1:0] tsum_next;
    logic [NCHAN-1:0][CHAN_W-1:0] sat;
    logic [TSUM_W-FRAC_W-1:0]     hi [NCHAN];
    res_t                         res;

    always_comb
    begin
        for (int ch = 0; ch < NCHAN; ch++)
        begin
            tsum_next[ch] = '0;
            for (int j = 0; j < WIN; j++)
            begin
                tsum_next[ch] = tsum_next[ch] + TSUM_W'(csum_all[j][ch]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tsum_reg <= tsum_next;
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < NCHAN; ch++)
        begin
            hi[ch]  = tsum_reg[ch][TSUM_W-1:FRAC_W];
            sat[ch] = (hi[ch] > (TSUM_W-FRAC_W)'(255)) ? '1 : hi[ch][CHAN_W-1:0];
        end
        res.pix = pixel_t'(sat);
        res.pos = pos5_reg;
    end

    // ------------------------------------------------------------------
    // Output register with skid. A result that meets a stalled, full output
    // register parks in the skid register and holds the pipeline.
    // ------------------------------------------------------------------
    res_t out_data_reg;
    res_t skid_data_reg;
    logic out_take;
    logic res_fire;
    logic out_valid_next;
    logic skid_valid_next;

    assign out_take = !out_valid_reg || !out_stall;
    assign res_fire = adv && v5_reg;

    always_comb
    begin
        if (out_take)
        begin
            out_valid_next  = skid_valid_reg || res_fire;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next  = 1'b1;
            skid_valid_next = skid_valid_reg || res_fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (res_fire)
            begin
                out_data_reg <= res;
            end
        end
        else if (res_fire)
        begin
            skid_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_b     = out_data_reg.pix.b;
    assign out_g     = out_data_reg.pix.g;
    assign out_r     = out_data_reg.pix.r;
    assign out_row   = out_data_reg.pos.row;
    assign out_col   = out_data_reg.pos.col;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The skid register only holds a transaction behind a full output register.
    `GBWF_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid full while output empty")
    // The skid register fills only when the output was full and stalled.
    `GBWF_ASSERT_IMP(a_skid_fill_cause, clk, rst_n, $rose(skid_valid_reg), $past(out_valid_reg) && $past(out_stall), "skid filled without a stalled output")
    // A frame start places the pixel at row 0, column 0, so the counter lands on column 1 or on the next row.
    `GBWF_ASSERT_NXT(a_frame_restart, clk, rst_n, in_accept && frame_start, (row_reg == ROW_W'(0) && col_reg == COL_W'(1)) || (row_reg == ROW_W'(1) && col_reg == COL_W'(0)), "raster position not restarted by frame start")

endmodule

// File: verif/tb_gaussian_blur_window_filter_core.sv
// Self-checking testbench for the Gaussian window filter core. Holds a filtered-pixel scoreboard
// class and the stimulus, configuration and checking processes that surround one instance.
// Depends on gbwf_pkg and gaussian_blur_window_filter_core.
`timescale 1ns / 1ps

module tb_gaussian_blur_window_filter_core
    import gbwf_pkg::*;
();

    // Tracks raster position, line storage and the 5x5 window exactly as the core does. For
    // every accepted pixel it works out whether a filtered pixel is due, and queues it in
    // arrival order.
    class blur_scoreboard;
        logic [WIDTH_W-1:0]           width_reg;
        logic [RAD_W-1:0]             radius_reg;
        weights_t                     wts;
        pixel_t                       line_mem [0:LINES*MAX_WIDTH-1];
        pixel_t [WIN-1:0][WIN-1:0]    win;
        int                           col_cnt;
        int                           row_cnt;
        res_t                         filtered_due [$];
        int                           mismatch_count;
        int                           checked_count;
        int                           max_row_seen;

        function new();
            width_reg  = RST_IMAGE_WIDTH;
            radius_reg = RST_KERNEL_RADIUS;
            wts = {RST_WEIGHT_CENTER, RST_WEIGHT_EDGE_ONE, RST_WEIGHT_DIAG_ONE,
                   RST_WEIGHT_EDGE_TWO, RST_WEIGHT_KNIGHT, RST_WEIGHT_DIAG_TWO};
            win = '0;
            foreach (line_mem[i])
                line_mem[i] = '0;
            col_cnt        = 0;
            row_cnt        = 0;
            mismatch_count = 0;
            checked_count  = 0;
            max_row_seen   = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_IMAGE_WIDTH:     width_reg     = data[WIDTH_W-1:0];
                REG_KERNEL_RADIUS:   radius_reg    = data[RAD_W-1:0];
                REG_WEIGHT_CENTER:   wts.center    = data;
                REG_WEIGHT_EDGE_ONE: wts.edge_one  = data;
                REG_WEIGHT_DIAG_ONE: wts.diag_one  = data;
                REG_WEIGHT_EDGE_TWO: wts.edge_two  = data;
                REG_WEIGHT_KNIGHT:   wts.knight    = data;
                REG_WEIGHT_DIAG_TWO: wts.diag_two  = data;
                default: ;
            endcase
        endfunction

        // Zero acts as one pixel and anything past the line length is clamped to it.
        function int eff_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > MAX_WIDTH)
                return MAX_WIDTH;
            return int'(width_reg);
        endfunction

        function int eff_radius();
            if (radius_reg == 0)
                return 1;
            if (radius_reg > MAX_RADIUS)
                return MAX_RADIUS;
            return int'(radius_reg);
        endfunction

        // The weight depends only on the sorted pair of distances from the center.
        function logic [WGT_W-1:0] ring_weight(int near, int far);
            if (far == 0)
                return wts.center;
            if (far == 1)
                return (near == 0) ? wts.edge_one : wts.diag_one;
            if (near == 0)
                return wts.edge_two;
            if (near == 1)
                return wts.knight;
            return wts.diag_two;
        endfunction

        function logic [CHAN_W-1:0] clip_sum(logic [31:0] acc);
            return (acc[31:16] > 16'd255) ? 8'hFF : acc[23:16];
        endfunction

        function void accept_pixel(pixel_t px, logic fs);
            int               w;
            int               rad;
            int               col;
            int               row;
            int               slot;
            int               ctr;
            int               di;
            int               dj;
            logic [WGT_W-1:0] wt;
            logic [31:0]      acc_b;
            logic [31:0]      acc_g;
            logic [31:0]      acc_r;
            pixel_t           tap;
            res_t             due;
            w   = eff_width();
            rad = eff_radius();
            if (fs)
            begin
                col_cnt = 0;
                row_cnt = 0;
            end
            // A width lowered under the current column pushes this pixel to the next row.
            if (col_cnt >= w)
            begin
                col_cnt = 0;
                row_cnt = (row_cnt + 1) % MAX_HEIGHT;
            end
            col  = col_cnt;
            row  = row_cnt;
            slot = row % LINES;
            for (int i = 0; i < WIN; i++)
                for (int j = 0; j < WIN - 1; j++)
                    win[i][j] = win[i][j+1];
            win[WIN-1][WIN-1] = px;
            for (int k = 1; k <= LINES; k++)
                win[WIN-1-k][WIN-1] = line_mem[((slot + LINES - k) % LINES) * MAX_WIDTH + col];
            line_mem[slot * MAX_WIDTH + col] = px;
            if (col + 1 >= w)
            begin
                col_cnt = 0;
                row_cnt = (row + 1) % MAX_HEIGHT;
            end
            else
            begin
                col_cnt = col + 1;
            end
            if (row < 2 * rad || col < 2 * rad)
                return;
            ctr   = WIN - 1 - rad;
            acc_b = '0;
            acc_g = '0;
            acc_r = '0;
            for (int i = ctr - rad; i <= ctr + rad; i++)
            begin
                for (int j = ctr - rad; j <= ctr + rad; j++)
                begin
                    di    = (i > ctr) ? i - ctr : ctr - i;
                    dj    = (j > ctr) ? j - ctr : ctr - j;
                    wt    = (di <= dj) ? ring_weight(di, dj) : ring_weight(dj, di);
                    tap   = win[i][j];
                    acc_b += wt * tap.b;
                    acc_g += wt * tap.g;
                    acc_r += wt * tap.r;
                end
            end
            due.pix.b   = clip_sum(acc_b);
            due.pix.g   = clip_sum(acc_g);
            due.pix.r   = clip_sum(acc_r);
            due.pos.row = ROW_W'(row - rad);
            due.pos.col = COL_W'(col - rad);
            filtered_due.push_back(due);
        endfunction

        function void check_filtered(res_t got);
            res_t want;
            checked_count++;
            if (filtered_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected filtered pixel b=%0d g=%0d r=%0d at row %0d col %0d.",
                             got.pix.b, got.pix.g, got.pix.r, got.pos.row, got.pos.col);
                return;
            end
            want = filtered_due.pop_front();
            if (int'(got.pos.row) > max_row_seen)
                max_row_seen = int'(got.pos.row);
            if (got.pix.b !== want.pix.b || got.pix.g !== want.pix.g
                || got.pix.r !== want.pix.r
                || got.pos.row !== want.pos.row || got.pos.col !== want.pos.col)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("Mismatch: expected b=%0d g=%0d r=%0d row %0d col %0d,",
                             want.pix.b, want.pix.g, want.pix.r, want.pos.row, want.pos.col);
                    $display("          got b=%0d g=%0d r=%0d row %0d col %0d.",
                             got.pix.b, got.pix.g, got.pix.r, got.pos.row, got.pos.col);
                end
            end
        endfunction
    endclass

    // Cycles allowed after the last filtered pixel before the registers change. The margin
    // covers a pixel that is still in flight in the core and produces nothing.
    localparam int SETTLE_CYCLES = 10;
    // Length of the long output hold that forces the core to stall its input.
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_PIXELS = 750;
    // Width of the first frame. No later setting is wider, so every column that any later
    // window reads has been written in all four stored rows.
    localparam int FIRST_WIDTH = 48;
    // The slowest correct run has about 1500 pixels, each costing at most a sender gap and a
    // receiver stall, which stays under 0.25 ms. The limit is eight times that.
    localparam int RUN_LIMIT_NS = 2_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [CHAN_W-1:0]     pixel_b;
    logic [CHAN_W-1:0]     pixel_g;
    logic [CHAN_W-1:0]     pixel_r;
    logic                  frame_start;
    logic                  out_valid;
    logic                  out_stall;
    logic [CHAN_W-1:0]     out_b;
    logic [CHAN_W-1:0]     out_g;
    logic [CHAN_W-1:0]     out_r;
    logic [ROW_W-1:0]      out_row;
    logic [COL_W-1:0]      out_col;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    blur_scoreboard sb;

    // Idle switches for the two sides. The phases turn them on or off so that the run has
    // both stretches of random gaps and stretches at full rate.
    bit tx_idle_en = 1'b0;
    bit rx_idle_en = 1'b0;
    // Remaining stall cycles drawn after the last output transaction, and the remaining
    // cycles of a long hold requested by the stimulus thread.
    int rx_wait   = 0;
    int hold_left = 0;

    int pixel_count    = 0;
    int settings_count = 0;
    int random_count   = 0;

    gaussian_blur_window_filter_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_b     (pixel_b),
        .pixel_g     (pixel_g),
        .pixel_r     (pixel_r),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_b       (out_b),
        .out_g       (out_g),
        .out_r       (out_r),
        .out_row     (out_row),
        .out_col     (out_col),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Sample values favor the two ends of the range so that zero and full-scale windows
    // show up often.
    function automatic logic [CHAN_W-1:0] rand_level();
        logic [CHAN_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = '1;
            default: v = CHAN_W'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    function automatic logic [WGT_W-1:0] rand_weight();
        return WGT_W'($urandom_range(0, 65535) >> $urandom_range(0, 3));
    endfunction

    // Some settings use all-zero or all-full weights; the rest draw each weight on its own,
    // which often sums past one and exercises the saturation.
    function automatic weights_t rand_weights();
        weights_t w;
        case ($urandom_range(0, 5))
            0:       w = '0;
            1:       w = '1;
            default: w = {rand_weight(), rand_weight(), rand_weight(),
                          rand_weight(), rand_weight(), rand_weight()};
        endcase
        return w;
    endfunction

    // One register write transaction. Called at a falling edge; returns at a falling edge
    // with the valid still high so that back-to-back writes never toggle it within a step.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] width_val,
                             input logic [CFG_DATA_W-1:0] rad_val,
                             input weights_t w);
        write_reg(REG_IMAGE_WIDTH, width_val);
        write_reg(REG_KERNEL_RADIUS, rad_val);
        write_reg(REG_WEIGHT_CENTER, w.center);
        write_reg(REG_WEIGHT_EDGE_ONE, w.edge_one);
        write_reg(REG_WEIGHT_DIAG_ONE, w.diag_one);
        write_reg(REG_WEIGHT_EDGE_TWO, w.edge_two);
        write_reg(REG_WEIGHT_KNIGHT, w.knight);
        write_reg(REG_WEIGHT_DIAG_TWO, w.diag_two);
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    // One input transaction. The valid is dropped only when a gap is drawn, so a pixel that
    // follows at full rate keeps it high without a second assignment in the same step.
    task automatic send_pixel(input pixel_t px, input logic fs);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        pixel_b     <= px.b;
        pixel_g     <= px.g;
        pixel_r     <= px.r;
        frame_start <= fs;
        do @(posedge clk); while (in_stall);
        sb.accept_pixel(px, fs);
        pixel_count++;
        @(negedge clk);
    endtask

    // Random raster content. A noisy burst also drops stray frame starts into the stream,
    // which cuts frames short at arbitrary positions.
    task automatic send_burst(input int count, input bit start_fs, input bit noisy);
        pixel_t px;
        logic   fs;
        for (int i = 0; i < count; i++)
        begin
            px.b = rand_level();
            px.g = rand_level();
            px.r = rand_level();
            fs   = (i == 0 && start_fs) || (noisy && $urandom_range(0, 49) == 0);
            send_pixel(px, fs);
        end
    endtask

    // Stops offering pixels and waits until every queued filtered pixel has been taken.
    // It always waits for a falling edge first, so the valid is never lowered and
    // raised again in one step.
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        do @(negedge clk); while (sb.filtered_due.size() != 0);
        repeat (settle) @(negedge clk);
    endtask

    // Output side. The stall is driven at the falling edge only: first any long hold, then
    // the per-transaction wait drawn by the checker below, otherwise ready.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Every output transaction is compared with the oldest filtered pixel still due. The
    // outputs are read at the rising edge, before the core updates them.
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.pix.b   = out_b;
            got.pix.g   = out_g;
            got.pix.r   = out_r;
            got.pos.row = out_row;
            got.pos.col = out_col;
            sb.check_filtered(got);
            rx_wait = rx_idle_en ? $urandom_range(0, 6) : 0;
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Run limit reached with %0d filtered pixels outstanding.",
                 sb.filtered_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int                    rows;
        int                    count;
        bit                    noisy;
        bit                    start_fs;
        logic [CFG_DATA_W-1:0] width_val;
        logic [CFG_DATA_W-1:0] rad_val;
        weights_t              wts;
        pixel_t                px;

        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        pixel_b     = '0;
        pixel_g     = '0;
        pixel_r     = '0;
        frame_start = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_IMAGE_WIDTH;
        cfg_data    = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The line memories are not cleared by reset. A first frame at the widest width used
        // in this run, with the 5x5 kernel, writes every column of rows 0 to 3 before any
        // result can be due, so no later window ever reads storage that was never written.
        // The radius value of three clamps to two here. Row 4 then yields results out to the
        // far columns.
        configure(CFG_DATA_W'(FIRST_WIDTH), 16'd3,
                  {16'd10000, 16'd8000, 16'd6000, 16'd3000, 16'd2000, 16'd700});
        send_burst(5 * FIRST_WIDTH, 1'b1, 1'b0);
        drain(SETTLE_CYCLES);

        // A width of four is narrower than the 5x5 kernel, so nothing comes out.
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        configure(16'd4, 16'd3, '1);
        px = '1;
        send_pixel(px, 1'b1);
        for (int i = 0; i < 4; i++)
        begin
            px = '0;
            send_pixel(px, 1'b0);
        end
        drain(SETTLE_CYCLES);

        // Width zero acts as one column. The frame is left mid-row, so the first pixel here
        // also shows a width lowered below the current column moving on to the next row.
        configure(16'd0, 16'd1, '1);
        px = '1;
        send_pixel(px, 1'b0);
        send_pixel(px, 1'b0);
        drain(SETTLE_CYCLES);

        // Radius zero acts as the 3x3 kernel. Only the center weight is set, so the three
        // results are the center sample scaled by just under one.
        configure(16'd5, 16'd0, {16'hFFFF, 80'h0});
        for (int i = 0; i < 15; i++)
        begin
            case (i % 4)
                0:       px = '0;
                1:       px = '1;
                2:       px = {8'hAA, 8'h55, 8'hF0};
                default: px = {8'h55, 8'hAA, 8'h0F};
            endcase
            send_pixel(px, i == 0);
        end
        drain(SETTLE_CYCLES);

        // The output is held for a long stretch while pixels keep coming at full rate, which
        // fills the core and stalls its input. Halfway through, the sender waits until every
        // result has come before going on with the same frame.
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        configure(16'd8, 16'd2, rand_weights());
        hold_left = LONG_HOLD_CYCLES;
        send_burst(48, 1'b1, 1'b0);
        drain(0);
        send_burst(48, 1'b0, 1'b0);
        drain(SETTLE_CYCLES);

        // Random settings, mostly narrow images with whole frames and a partial last row.
        // Some settings continue the previous frame instead of starting a new one, and some
        // carry stray frame starts.
        while (random_count < RANDOM_PIXELS)
        begin
            case ($urandom_range(0, 9))
                0:       width_val = CFG_DATA_W'($urandom_range(0, 2));
                1, 2:    width_val = CFG_DATA_W'($urandom_range(13, FIRST_WIDTH));
                default: width_val = CFG_DATA_W'($urandom_range(3, 12));
            endcase
            rad_val = CFG_DATA_W'($urandom_range(0, 3));
            wts     = rand_weights();
            configure(width_val, rad_val, wts);
            tx_idle_en = ($urandom_range(0, 2) != 0);
            rx_idle_en = ($urandom_range(0, 2) != 0);
            start_fs   = ($urandom_range(0, 3) != 0);
            noisy      = ($urandom_range(0, 3) == 0);
            rows  = 2 * sb.eff_radius() + 1 + $urandom_range(0, 3);
            count = sb.eff_width() * rows + $urandom_range(0, sb.eff_width() - 1);
            send_burst(count, start_fs, noisy);
            random_count += count;
            drain(SETTLE_CYCLES);
        end

        $display("Covered %0d pixels over %0d register settings and a %0d-cycle output hold.",
                 pixel_count, settings_count, LONG_HOLD_CYCLES);
        $display("Checked %0d filtered pixels up to row %0d: %0d mismatches, %0d never arrived.",
                 sb.checked_count, sb.max_row_seen, sb.mismatch_count,
                 sb.filtered_due.size());
        if (sb.mismatch_count == 0 && sb.filtered_due.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/gbwf_pkg.sv
src/gbwf_line_buf.sv
src/gbwf_cell.sv
src/gaussian_blur_window_filter_core.sv
verif/tb_gaussian_blur_window_filter_core.sv
